[design/tsb_pkg.sv]
// shared types, constants and helpers for the periodic timer slot bank
package tsb_pkg;

    // bank size and derived widths
    localparam int SLOTS = 8;
    localparam int POS_W = $clog2(SLOTS + 1);
    localparam int IDX_W = 4;

    localparam logic [POS_W-1:0] SLOTS_POS = POS_W'(SLOTS);
    localparam logic [7:0]       SLOTS_8   = 8'(SLOTS);

    // operation codes of an input beat
    typedef enum logic [2:0] {
        OP_CREATE     = 3'd0,
        OP_REGISTER   = 3'd1,
        OP_STOP       = 3'd2,
        OP_UNREGISTER = 3'd3,
        OP_TICK       = 3'd4
    } op_t;

    // kinds of result beat
    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_ALLOC  = 2'd1,
        KIND_EXPIRY = 2'd2
    } kind_t;

    // command token walking the cell row
    typedef struct packed {
        logic             valid;
        op_t              op;
        logic [7:0]       slot;
        logic [7:0]       tag;
        logic [31:0]      period;
        logic             ok;
        logic             found;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] idx;
        logic             pend_valid;
        logic [POS_W-1:0] pend_idx;
        logic [7:0]       pend_tag;
    } tok_t;

    // one result beat
    typedef struct packed {
        logic             valid;
        kind_t            kind;
        logic [IDX_W-1:0] idx;
        logic             status;
        logic [7:0]       tag;
        logic             last;
    } res_t;

    // slot position to the result index field, masked to its width
    function automatic logic [IDX_W-1:0] to_idx(input logic [POS_W-1:0] p);
        logic [POS_W+IDX_W-1:0] w;
        w = {{IDX_W{1'b0}}, p};
        return w[IDX_W-1:0];
    endfunction

endpackage

[design/tsb_cell.sv]
// one timer slot cell: holds the slot state and passes the command token on
module tsb_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  tsb_pkg::tok_t tok_in,
    output tsb_pkg::tok_t tok_out,
    output tsb_pkg::res_t emit
);
    import tsb_pkg::*;

    logic        active_reg,  active_next;
    logic [31:0] period_reg,  period_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [7:0]  tag_reg,     tag_next;
    tok_t        tok_reg,     tok_next;

    logic        hit;
    logic        ticking;
    logic        fire;
    logic [31:0] elapsed_inc;

    // token handling for this slot
    always_comb
    begin
        active_next  = active_reg;
        period_next  = period_reg;
        elapsed_next = elapsed_reg;
        tag_next     = tag_reg;
        tok_next     = tok_in;
        tok_next.pos = tok_in.pos + POS_W'(1);
        emit         = '0;

        hit         = (tok_in.slot == 8'(tok_in.pos));
        elapsed_inc = elapsed_reg + 32'd1;
        ticking     = active_reg && (tag_reg != 8'd0);
        fire        = ticking && (elapsed_inc >= period_reg);

        if (tok_in.valid)
        begin
            case (tok_in.op)
                OP_CREATE:
                begin
                    if (!tok_in.found && !active_reg)
                    begin
                        active_next    = 1'b1;
                        period_next    = '0;
                        elapsed_next   = '0;
                        tag_next       = '0;
                        tok_next.found = 1'b1;
                        tok_next.idx   = tok_in.pos;
                    end
                end
                OP_REGISTER:
                begin
                    if (tok_in.ok && hit)
                    begin
                        active_next  = 1'b1;
                        period_next  = tok_in.period;
                        elapsed_next = '0;
                        tag_next     = tok_in.tag;
                    end
                end
                OP_STOP:
                begin
                    if (tok_in.ok && hit)
                    begin
                        active_next = 1'b0;
                    end
                end
                OP_UNREGISTER:
                begin
                    if (tok_in.ok && hit)
                    begin
                        active_next = 1'b0;
                        tag_next    = '0;
                    end
                end
                OP_TICK:
                begin
                    if (ticking)
                    begin
                        elapsed_next = fire ? 32'd0 : elapsed_inc;
                    end
                    // an earlier expiry is now known not to be the final one
                    if (fire)
                    begin
                        if (tok_in.pend_valid)
                        begin
                            emit.valid  = 1'b1;
                            emit.kind   = KIND_EXPIRY;
                            emit.idx    = to_idx(tok_in.pend_idx);
                            emit.status = 1'b0;
                            emit.tag    = tok_in.pend_tag;
                            emit.last   = 1'b0;
                        end
                        tok_next.pend_valid = 1'b1;
                        tok_next.pend_idx   = tok_in.pos;
                        tok_next.pend_tag   = tag_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // slot state and token register, held while the row is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            period_reg  <= '0;
            elapsed_reg <= '0;
            tag_reg     <= '0;
            tok_reg     <= '0;
        end
        else if (advance)
        begin
            active_reg  <= active_next;
            period_reg  <= period_next;
            elapsed_reg <= elapsed_next;
            tag_reg     <= tag_next;
            tok_reg     <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

[design/tsb_out.sv]
// result stage: forms the closing beat and holds the output register
module tsb_out (
    input  logic          clk,
    input  logic          rst_n,
    input  tsb_pkg::res_t cell_res,
    input  tsb_pkg::tok_t tail_tok,
    input  logic          out_ready,
    output logic          out_valid,
    output tsb_pkg::res_t out_beat,
    output logic          stall
);
    import tsb_pkg::*;

    res_t tail_res;
    res_t want;
    logic load;

    logic out_valid_reg, out_valid_next;
    res_t out_reg,       out_next;

    // closing beat once the token leaves the last cell
    always_comb
    begin
        tail_res = '0;
        if (tail_tok.valid)
        begin
            case (tail_tok.op)
                OP_CREATE:
                begin
                    tail_res.valid  = 1'b1;
                    tail_res.kind   = KIND_ALLOC;
                    tail_res.idx    = to_idx(tail_tok.found ? tail_tok.idx : SLOTS_POS);
                    tail_res.status = !tail_tok.found;
                    tail_res.last   = 1'b1;
                end
                OP_REGISTER, OP_STOP, OP_UNREGISTER:
                begin
                    tail_res.valid  = 1'b1;
                    tail_res.kind   = KIND_STATUS;
                    tail_res.status = !tail_tok.ok;
                    tail_res.last   = 1'b1;
                end
                OP_TICK:
                begin
                    if (tail_tok.pend_valid)
                    begin
                        tail_res.valid = 1'b1;
                        tail_res.kind  = KIND_EXPIRY;
                        tail_res.idx   = to_idx(tail_tok.pend_idx);
                        tail_res.tag   = tail_tok.pend_tag;
                        tail_res.last  = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // at most one source offers a beat in a cycle
    always_comb
    begin
        want           = cell_res.valid ? cell_res : tail_res;
        load           = want.valid && (!out_valid_reg || out_ready);
        stall          = want.valid && !load;
        out_next       = load ? want : out_reg;
        out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

    // a cell beat and the closing beat never compete
    a_single_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(cell_res.valid && tail_res.valid))
        else $error("cell beat and closing beat offered together");

endmodule

[design/periodic_timer_slot_bank_top.sv]
// top level of the periodic timer slot bank: entry register, cell row, result stage
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------
//   input    | in_valid, in_ready  | op, slot, handler_tag, period
//   output   | out_valid, out_ready| kind, slot_index, status, fired_tag, last
//
// an accepted beat enters a token register and walks the cell row one cell per
// cycle while the row is not stalled; the next beat is taken only once the token
// has left the last cell.
// the row stalls as a whole while a result beat waits on a full output register.
// reset clears every slot to inactive with zero period, count and tag.
module periodic_timer_slot_bank_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [7:0]  slot,
    input  logic [7:0]  handler_tag,
    input  logic [31:0] period,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [3:0]  slot_index,
    output logic        status,
    output logic [7:0]  fired_tag,
    output logic        last
);
    import tsb_pkg::*;

    tok_t tok [0:SLOTS];
    res_t emit [0:SLOTS-1];
    res_t cell_res;
    res_t out_beat;

    logic           accept;
    logic           advance;
    logic           stall;
    logic [SLOTS:0] tok_vld;

    logic busy_reg, busy_next;
    tok_t tok0_reg, tok0_next;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    assign advance  = !stall;

    // entry token with the argument checks done up front
    always_comb
    begin
        tok0_next = tok0_reg;
        if (accept)
        begin
            tok0_next        = '0;
            tok0_next.valid  = 1'b1;
            tok0_next.op     = op_t'(op);
            tok0_next.slot   = slot;
            tok0_next.tag    = handler_tag;
            tok0_next.period = period;
            case (op_t'(op))
                OP_REGISTER:
                    tok0_next.ok = (slot < SLOTS_8) && (handler_tag != 8'd0)
                                   && (period != 32'd0);
                OP_STOP, OP_UNREGISTER:
                    tok0_next.ok = (slot < SLOTS_8);
                default:
                    tok0_next.ok = 1'b1;
            endcase
        end
        else if (advance)
        begin
            tok0_next.valid = 1'b0;
        end

        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (tok[SLOTS].valid && advance)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            tok0_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            tok0_reg <= tok0_next;
        end
    end

    assign tok[0] = tok0_reg;

    // row of slot cells
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        tsb_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1]),
            .emit    (emit[i])
        );
    end

    // merge cell beats: only the cell holding the token can offer one
    always_comb
    begin
        cell_res = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            cell_res = res_t'(cell_res | emit[i]);
        end
        for (int i = 0; i <= SLOTS; i++)
        begin
            tok_vld[i] = tok[i].valid;
        end
    end

    tsb_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_res  (cell_res),
        .tail_tok  (tok[SLOTS]),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_beat  (out_beat),
        .stall     (stall)
    );

    assign kind       = out_beat.kind;
    assign slot_index = out_beat.idx;
    assign status     = out_beat.status;
    assign fired_tag  = out_beat.tag;
    assign last       = out_beat.last;

    // one token at most in flight
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vld))
        else $error("more than one token in the cell row");

    // busy tracks exactly the presence of a token
    a_busy_token: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (|tok_vld))
        else $error("busy flag out of step with token");

    // the row only stalls with an item in progress
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stall |-> busy_reg)
        else $error("stall with no item in progress");

endmodule

[tb/sv/tsb_checker.sv]
// checker for the timer slot bank: watches both channels, predicts and compares result beats
`timescale 1ns / 100ps

module tsb_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  op,
    input  logic [7:0]  slot,
    input  logic [7:0]  handler_tag,
    input  logic [31:0] period,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  kind,
    input  logic [3:0]  slot_index,
    input  logic        status,
    input  logic [7:0]  fired_tag,
    input  logic        last,
    output int          fail_count,
    output int          awaited,
    output int          beats_checked,
    output int          expiries_due
);
    import tsb_pkg::*;

    // one expected result beat
    typedef struct packed {
        kind_t      kind;
        logic [3:0] idx;
        logic       status;
        logic [7:0] tag;
        logic       last;
    } beat_t;

    beat_t      awaited_q [$];
    logic       slot_on      [SLOTS];
    logic [31:0] slot_len    [SLOTS];
    logic [31:0] slot_count  [SLOTS];
    logic [7:0] slot_handler [SLOTS];
    int         errors;
    int         checked;
    int         expiries;

    assign fail_count    = errors;
    assign beats_checked = checked;
    assign expiries_due  = expiries;

    function automatic beat_t make_beat(kind_t k, logic [3:0] i, logic s, logic [7:0] t,
                                        logic l);
        beat_t b;
        b.kind   = k;
        b.idx    = i;
        b.status = s;
        b.tag    = t;
        b.last   = l;
        return b;
    endfunction

    // bank behaviour for one accepted input beat
    task automatic bank_apply(input logic [2:0] code, input logic [7:0] target,
                              input logic [7:0] handler, input logic [31:0] ticks);
        beat_t fired [$];
        logic  found;
        int    i;
        found = 1'b0;
        case (code)
            OP_CREATE:
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    if (!found && !slot_on[i])
                    begin
                        slot_on[i]      = 1'b1;
                        slot_len[i]     = '0;
                        slot_count[i]   = '0;
                        slot_handler[i] = '0;
                        awaited_q.push_back(make_beat(KIND_ALLOC, 4'(i), 1'b0, 8'd0, 1'b1));
                        found = 1'b1;
                    end
                end
                // bank full
                if (!found)
                    awaited_q.push_back(make_beat(KIND_ALLOC, 4'(SLOTS), 1'b1, 8'd0, 1'b1));
            end
            OP_REGISTER:
            begin
                if (target >= SLOTS || handler == 8'd0 || ticks == 32'd0)
                    awaited_q.push_back(make_beat(KIND_STATUS, 4'd0, 1'b1, 8'd0, 1'b1));
                else
                begin
                    slot_handler[target] = handler;
                    slot_len[target]     = ticks;
                    slot_count[target]   = '0;
                    slot_on[target]      = 1'b1;
                    awaited_q.push_back(make_beat(KIND_STATUS, 4'd0, 1'b0, 8'd0, 1'b1));
                end
            end
            OP_STOP, OP_UNREGISTER:
            begin
                if (target >= SLOTS)
                    awaited_q.push_back(make_beat(KIND_STATUS, 4'd0, 1'b1, 8'd0, 1'b1));
                else
                begin
                    slot_on[target] = 1'b0;
                    if (code == OP_UNREGISTER)
                        slot_handler[target] = '0;
                    awaited_q.push_back(make_beat(KIND_STATUS, 4'd0, 1'b0, 8'd0, 1'b1));
                end
            end
            OP_TICK:
            begin
                // advance armed slots, expiries in index order
                for (i = 0; i < SLOTS; i++)
                begin
                    if (slot_on[i] && slot_handler[i] != 8'd0)
                    begin
                        slot_count[i] = slot_count[i] + 32'd1;
                        if (slot_count[i] >= slot_len[i])
                        begin
                            slot_count[i] = '0;
                            fired.push_back(make_beat(KIND_EXPIRY, 4'(i), 1'b0,
                                                      slot_handler[i], 1'b0));
                        end
                    end
                end
                if (fired.size() > 0)
                    fired[fired.size() - 1].last = 1'b1;
                expiries += fired.size();
                while (fired.size() > 0)
                    awaited_q.push_back(fired.pop_front());
            end
            default:
            begin
                // unused codes are ignored
            end
        endcase
    endtask

    function automatic void match_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // compare result beats, then fold in the accepted input beat
    always @(posedge clk or negedge rst_n)
    begin
        beat_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_on[i]      = 1'b0;
                slot_len[i]     = '0;
                slot_count[i]   = '0;
                slot_handler[i] = '0;
            end
            awaited_q.delete();
            errors   = 0;
            checked  = 0;
            expiries = 0;
            awaited <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                checked++;
                if (awaited_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat, kind %0d slot %0d tag %0d",
                             $time, kind, slot_index, fired_tag);
                    errors++;
                end
                else
                begin
                    want = awaited_q.pop_front();
                    match_field("kind", 32'(want.kind), 32'(kind));
                    match_field("slot_index", 32'(want.idx), 32'(slot_index));
                    match_field("status", 32'(want.status), 32'(status));
                    match_field("fired_tag", 32'(want.tag), 32'(fired_tag));
                    match_field("last", 32'(want.last), 32'(last));
                end
            end
            if (in_valid && in_ready)
                bank_apply(op, slot, handler_tag, period);
            awaited <= awaited_q.size();
        end
    end

endmodule

[tb/sv/tb_periodic_timer_slot_bank_top.sv]
// testbench top for the timer slot bank: clock, reset, stimulus, output stalls and verdict
`timescale 1ns / 100ps

module tb_periodic_timer_slot_bank_top;
    import tsb_pkg::*;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam int RANDOM_ITEMS = 390;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4 * (SLOTS + 2);
    localparam int CYCLE_LIMIT  = 400000;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [2:0]  op          = '0;
    logic [7:0]  slot        = '0;
    logic [7:0]  handler_tag = '0;
    logic [31:0] period      = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [1:0]  kind;
    logic [3:0]  slot_index;
    logic        status;
    logic [7:0]  fired_tag;
    logic        last;

    int fail_count;
    int awaited;
    int beats_checked;
    int expiries_due;

    logic calm     = 1'b0;
    logic hold_req = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    int   cycles    = 0;
    int   items_sent = 0;

    periodic_timer_slot_bank_top dut (.*);

    tsb_checker checker_i (
        .fail_count    (fail_count),
        .awaited       (awaited),
        .beats_checked (beats_checked),
        .expiries_due  (expiries_due),
        .*
    );

    // clock
    always #5 clk = ~clk;

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_req && !hold_seen)
        begin
            hold_seen <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (calm)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= 23);
    end

    // offer one beat, holding it until accepted
    task automatic send_beat(input logic [2:0] code, input logic [7:0] target,
                             input logic [7:0] handler, input logic [31:0] ticks);
        while (!calm && $urandom_range(0, 99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= code;
        slot        <= target;
        handler_tag <= handler;
        period      <= ticks;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        items_sent++;
    endtask

    function automatic logic [31:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 32'($urandom_range(1, 6));
        else if (r < 92)
            return 32'($urandom_range(7, 40));
        else
            return $urandom();
    endfunction

    function automatic logic [7:0] pick_slot();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        else
            return 8'($urandom_range(0, SLOTS - 1));
    endfunction

    // stimulus
    initial
    begin
        int counted;
        int r;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty tick, register before create, fill the bank past full
        send_beat(OP_TICK, 8'd0, 8'd0, 32'd0);
        send_beat(OP_REGISTER, 8'd5, 8'h3C, 32'd2);
        repeat (SLOTS) send_beat(OP_CREATE, 8'd0, 8'd0, 32'd0);
        // valid and rejected registrations
        send_beat(OP_REGISTER, 8'd0, 8'hFF, 32'd1);
        send_beat(OP_REGISTER, 8'd7, 8'h01, 32'd3);
        send_beat(OP_REGISTER, 8'd3, 8'hAA, 32'hFFFF_FFFF);
        send_beat(OP_REGISTER, SLOTS_8, 8'd5, 32'd3);
        send_beat(OP_REGISTER, 8'd255, 8'd5, 32'd3);
        send_beat(OP_REGISTER, 8'd2, 8'd0, 32'd4);
        send_beat(OP_REGISTER, 8'd2, 8'd7, 32'd0);
        // ticks with single and several expiries
        repeat (3) send_beat(OP_TICK, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        // stop and unregister, in and out of range
        send_beat(OP_STOP, 8'd0, 8'd0, 32'd0);
        send_beat(OP_UNREGISTER, 8'd7, 8'd0, 32'd0);
        send_beat(OP_STOP, 8'd255, 8'd0, 32'd0);
        send_beat(OP_UNREGISTER, SLOTS_8, 8'd0, 32'd0);
        // unused codes, then create reuses the freed slot
        send_beat(OP_SPARE_FIRST, 8'd1, 8'd1, 32'd1);
        send_beat(OP_SPARE_LAST, 8'd1, 8'd1, 32'd1);
        send_beat(OP_CREATE, 8'd0, 8'd0, 32'd0);

        // random part
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted == 100)
                hold_req <= 1'b1;
            calm <= (counted >= 200 && counted < 300);
            r = $urandom_range(0, 99);
            if (r < 34)
                send_beat(OP_TICK, 8'($urandom()), 8'($urandom()), $urandom());
            else if (r < 44)
                send_beat(OP_CREATE, 8'($urandom()), 8'($urandom()), $urandom());
            else if (r < 70)
                send_beat(OP_REGISTER, 8'($urandom_range(0, SLOTS - 1)),
                          8'($urandom_range(1, 255)), pick_period());
            else if (r < 79)
                send_beat(OP_STOP, pick_slot(), 8'($urandom()), $urandom());
            else if (r < 88)
                send_beat(OP_UNREGISTER, pick_slot(), 8'($urandom()), $urandom());
            else if (r < 91)
            begin
                // ignored codes do not count
                send_beat(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                          8'($urandom()), 8'($urandom()), $urandom());
                continue;
            end
            else
            begin
                // broken registration: bad slot, zero tag or zero period
                case ($urandom_range(0, 2))
                    0: send_beat(OP_REGISTER, 8'($urandom_range(SLOTS, 255)),
                                 8'($urandom_range(1, 255)), pick_period());
                    1: send_beat(OP_REGISTER, pick_slot(), 8'd0, pick_period());
                    default: send_beat(OP_REGISTER, pick_slot(),
                                       8'($urandom_range(0, 255)), 32'd0);
                endcase
            end
            counted++;
        end
        calm <= 1'b0;
        in_valid <= 1'b0;

        // drain outstanding results, then watch for strays
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d input beats sent, %0d result beats checked, %0d expiries",
                 items_sent, beats_checked, expiries_due);
        $display("summary: bank full, rejected fields, ignored codes and a long output stall seen");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
design/tsb_pkg.sv
design/tsb_cell.sv
design/tsb_out.sv
design/periodic_timer_slot_bank_top.sv
tb/sv/tsb_checker.sv
tb/sv/tb_periodic_timer_slot_bank_top.sv
